FILE: sv/mgru_pkg.sv
// ----------------------------------------------------------------------------
// mgru_pkg: shared definitions for the mixed graph reach update block
// Sizes, operation codes and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package mgru_pkg;

    // Largest number of graph nodes; one matrix row and one column per node.
    localparam int MAX_NODES    = 64;
    localparam int ROW_W        = MAX_NODES;
    localparam int NODE_W       = $clog2(MAX_NODES);
    localparam int CNT_W        = $clog2(MAX_NODES + 1);

    // Fixed field widths of the stream words.
    localparam int CFG_W        = 7;
    localparam int FIELD_NODE_W = 6;
    localparam int MASK_W       = 64;
    localparam int IN_FIELDS_W  = 2 * FIELD_NODE_W + MASK_W + 1;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = 8;

    localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 7'd64;

    typedef logic [ROW_W-1:0]  t_row;
    typedef logic [NODE_W-1:0] t_node;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef enum logic [1:0] {
        OP_ADD_DIR = 2'd0,
        OP_ADD_BI  = 2'd1,
        OP_PRUNE   = 2'd2,
        OP_CLEAR   = 2'd3
    } t_op;

    // Which row the matrix read port fetches.
    typedef enum logic [1:0] {
        RD_Y = 2'd0,
        RD_X = 2'd1,
        RD_Z = 2'd2
    } t_rd_sel;

    // Which update rule forms the row that is written back.
    typedef enum logic [1:0] {
        WR_X    = 2'd0,
        WR_Y    = 2'd1,
        WR_SCAN = 2'd2
    } t_wr_mode;

    typedef struct packed {
        logic     load_item;
        logic     cap_y;
        t_rd_sel  rd_sel;
        logic     wr_en;
        t_wr_mode wr_mode;
        logic     clear;
        logic     z_clr;
        logic     z_inc;
        logic     load_result;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic reject;
        logic n_zero;
        logic last_row;
        logic out_free;
    } t_sts;

endpackage

FILE: sv/mgru_ram.sv
// ----------------------------------------------------------------------------
// mgru_ram: generic single-write, single-read memory
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module mgru_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/mgru_dp.sv
// ----------------------------------------------------------------------------
// mgru_dp: datapath of the mixed graph reach update block
// Holds both matrices, the cached endpoint rows, the per-row valid and
// diagonal bits, the node count register and the result register.
// ----------------------------------------------------------------------------
module mgru_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [mgru_pkg::CFG_W-1:0]    i_cfg_wr_data,
    input  logic [mgru_pkg::IN_TDATA_W-1:0] i_in_data,
    input  logic [1:0]                    i_in_user,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [mgru_pkg::OUT_TDATA_W-1:0] o_out_data,
    input  mgru_pkg::t_cmd                i_cmd,
    output mgru_pkg::t_sts                o_sts
);
    import mgru_pkg::*;

    logic [CFG_W-1:0]        r_node_count;
    t_op                     r_op;
    logic [FIELD_NODE_W-1:0] r_a;
    logic [FIELD_NODE_W-1:0] r_b;
    t_row                    r_future;
    logic                    r_drop;
    logic                    r_reject;
    t_row                    r_rx, r_ry, r_ay;
    t_node                   r_z;
    logic [MAX_NODES-1:0]    r_valid;
    logic [MAX_NODES-1:0]    r_diag;
    logic                    r_rd_valid;
    logic                    r_out_valid;
    logic                    r_out_status;
    logic                    r_out_cycle;

    t_cnt       n;
    t_row       lower_mask;
    t_node      xi, yi, raddr, waddr;
    t_row       bit_x, bit_y;
    t_row       ram_r, ram_a, row_r, row_a;
    t_row       wr_r, wr_a;
    t_row       r1, a1, ry_e;
    logic       keep;
    logic       n_reject;
    logic [FIELD_NODE_W-1:0] in_a, in_b;
    t_op        in_op;

    assign n = (r_node_count > CFG_W'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                   : CNT_W'(r_node_count);

    always_comb begin
        for (int i = 0; i < MAX_NODES; i++) begin
            lower_mask[i] = (CNT_W'(i) < n);
        end
    end

    assign xi    = r_a[NODE_W-1:0];
    assign yi    = r_b[NODE_W-1:0];
    assign bit_x = ROW_W'(1) << xi;
    assign bit_y = ROW_W'(1) << yi;

    assign in_a  = i_in_data[FIELD_NODE_W-1:0];
    assign in_b  = i_in_data[2*FIELD_NODE_W-1:FIELD_NODE_W];
    assign in_op = t_op'(i_in_user);

    // An edge add must name nodes in use; a directed self edge is refused.
    assign n_reject = (in_op == OP_ADD_DIR || in_op == OP_ADD_BI) &&
                      ((CFG_W'(in_a) >= CFG_W'(n)) || (CFG_W'(in_b) >= CFG_W'(n)) ||
                       (in_op == OP_ADD_DIR && in_a == in_b));

    always_comb begin
        unique case (i_cmd.rd_sel)
            RD_Y:    raddr = yi;
            RD_X:    raddr = xi;
            RD_Z:    raddr = r_z;
            default: raddr = r_z;
        endcase
    end

    // A row that was never written since the last clear reads as zeros.
    assign row_r = r_rd_valid ? ram_r : '0;
    assign row_a = r_rd_valid ? ram_a : '0;

    // Scan update terms for a directed add; the second test sees the first.
    assign r1   = row_r[xi] ? (row_r | bit_y | r_ry) : row_r;
    assign a1   = row_r[xi] ? (row_a | r_ay) : row_a;
    assign ry_e = (r_z == yi) ? r1 : r_ry;
    assign keep = r_future[r_z];

    always_comb begin
        wr_r  = row_r;
        wr_a  = row_a;
        waddr = r_z;
        unique case (i_cmd.wr_mode)
            WR_X: begin
                waddr = xi;
                if (r_op == OP_ADD_DIR) begin
                    wr_r = row_r | bit_y | r_ry;
                    wr_a = row_a | r_ay;
                end else begin
                    wr_a = row_a | bit_y | r_ry;
                end
            end
            WR_Y: begin
                waddr = yi;
                wr_r  = r_ry;
                wr_a  = r_ay | bit_x | r_rx;
            end
            WR_SCAN: begin
                waddr = r_z;
                unique case (r_op)
                    OP_ADD_DIR: begin
                        wr_r = r1;
                        wr_a = a1[xi] ? (a1 | bit_y | ry_e) : a1;
                    end
                    OP_ADD_BI: begin
                        wr_a = row_a | (row_r[xi] ? (bit_y | r_ry) : '0)
                                     | (row_r[yi] ? (bit_x | r_rx) : '0);
                    end
                    OP_PRUNE: begin
                        wr_r = keep ? row_r : '0;
                        wr_a = (keep ? row_a : '0) & (r_drop ? ~wr_r : '1);
                    end
                    default: begin
                        wr_r = row_r;
                        wr_a = row_a;
                    end
                endcase
            end
            default: begin
                waddr = r_z;
            end
        endcase
    end

    mgru_ram #(.WIDTH(ROW_W), .DEPTH(MAX_NODES)) u_reach_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (waddr),
        .i_wdata (wr_r),
        .i_raddr (raddr),
        .o_rdata (ram_r)
    );

    mgru_ram #(.WIDTH(ROW_W), .DEPTH(MAX_NODES)) u_almost_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (waddr),
        .i_wdata (wr_a),
        .i_raddr (raddr),
        .o_rdata (ram_a)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= NODE_COUNT_RESET;
            r_valid      <= '0;
            r_diag       <= '0;
            r_out_valid  <= 1'b0;
            r_z          <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_node_count <= i_cfg_wr_data;
            end
            if (i_cmd.clear) begin
                r_valid <= '0;
                r_diag  <= '0;
            end else if (i_cmd.wr_en) begin
                r_valid[waddr] <= 1'b1;
                r_diag[waddr]  <= wr_r[waddr] | wr_a[waddr];
            end
            if (i_cmd.z_clr) begin
                r_z <= '0;
            end else if (i_cmd.z_inc) begin
                r_z <= r_z + NODE_W'(1);
            end
            if (i_cmd.load_result) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_rd_valid <= r_valid[raddr];
        if (i_cmd.load_item) begin
            r_op     <= in_op;
            r_a      <= in_a;
            r_b      <= in_b;
            r_future <= i_in_data[2*FIELD_NODE_W +: ROW_W];
            r_drop   <= i_in_data[2*FIELD_NODE_W + MASK_W];
            r_reject <= n_reject;
        end
        if (i_cmd.cap_y) begin
            r_ry <= row_r;
            r_ay <= row_a;
        end else if (i_cmd.wr_en && waddr == yi) begin
            r_ry <= wr_r;
            r_ay <= wr_a;
        end
        if (i_cmd.wr_en && waddr == xi) begin
            r_rx <= wr_r;
        end
        if (i_cmd.load_result) begin
            r_out_status <= r_reject;
            r_out_cycle  <= |(r_diag & lower_mask);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = {{(OUT_TDATA_W-2){1'b0}}, r_out_cycle, r_out_status};

    assign o_sts.op       = r_op;
    assign o_sts.reject   = r_reject;
    assign o_sts.n_zero   = (n == '0);
    assign o_sts.last_row = (CNT_W'(r_z) + CNT_W'(1)) == n;
    assign o_sts.out_free = !r_out_valid || i_out_ready;

endmodule

FILE: sv/mgru_ctrl.sv
// ----------------------------------------------------------------------------
// mgru_ctrl: controller of the mixed graph reach update block
// Sequences the clear, endpoint row loads, endpoint writes, the row scan and the
// hand-off of each result to the output register.
// ----------------------------------------------------------------------------
module mgru_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  mgru_pkg::t_sts i_sts,
    output mgru_pkg::t_cmd o_cmd
);
    import mgru_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE    = 10'b00_0000_0001,
        S_DECODE  = 10'b00_0000_0010,
        S_CLEAR   = 10'b00_0000_0100,
        S_RD_Y    = 10'b00_0000_1000,
        S_RD_X    = 10'b00_0001_0000,
        S_WR_X    = 10'b00_0010_0000,
        S_WR_Y    = 10'b00_0100_0000,
        S_SCAN_RD = 10'b00_1000_0000,
        S_SCAN_WR = 10'b01_0000_0000,
        S_FINISH  = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '{load_item: 1'b0, cap_y: 1'b0, rd_sel: RD_Z, wr_en: 1'b0,
                    wr_mode: WR_SCAN, clear: 1'b0, z_clr: 1'b0, z_inc: 1'b0,
                    load_result: 1'b0};
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    n_state         = S_DECODE;
                end
            end
            S_DECODE: begin
                o_cmd.z_clr = 1'b1;
                priority if (i_sts.reject) begin
                    n_state = S_FINISH;
                end else if (i_sts.op == OP_CLEAR) begin
                    n_state = S_CLEAR;
                end else if (i_sts.op == OP_PRUNE) begin
                    n_state = i_sts.n_zero ? S_FINISH : S_SCAN_RD;
                end else begin
                    n_state = S_RD_Y;
                end
            end
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state     = S_FINISH;
            end
            S_RD_Y: begin
                o_cmd.rd_sel = RD_Y;
                n_state      = S_RD_X;
            end
            S_RD_X: begin
                o_cmd.rd_sel = RD_X;
                o_cmd.cap_y  = 1'b1;
                n_state      = S_WR_X;
            end
            S_WR_X: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_mode = WR_X;
                n_state       = (i_sts.op == OP_ADD_BI) ? S_WR_Y : S_SCAN_RD;
            end
            S_WR_Y: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_mode = WR_Y;
                n_state       = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                o_cmd.rd_sel = RD_Z;
                n_state      = S_SCAN_WR;
            end
            S_SCAN_WR: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_mode = WR_SCAN;
                o_cmd.z_inc   = 1'b1;
                n_state       = i_sts.last_row ? S_FINISH : S_SCAN_RD;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.load_result = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

FILE: sv/mixed_graph_reach_update.sv
// ----------------------------------------------------------------------------
// mixed_graph_reach_update: incremental reachability over a mixed graph
// Keeps a directed reach matrix and an almost-reach matrix (paths through
// one bidirected edge) and updates them one operation word at a time.
// ----------------------------------------------------------------------------
// Each input word carries one operation: add a directed edge, add a
// bidirected edge, prune rows outside a future mask, or clear both
// matrices; each produces exactly one result word with a reject flag and
// a flag telling whether any node in use now reaches or almost-reaches
// itself. The block works on one word at a time. An edge add reads the
// rows of both endpoints, writes back the row of the first (and, for a
// bidirected add, of the second) and then scans every row in use; a prune
// only scans, and a clear or a rejected add skips the scan. In the scan,
// both matrices sit in memories with one read and one write port, and
// every row in use is read and written back in the following cycle, in
// ascending order, so that a row sees the updates already made to earlier
// rows. The result register lets the next word be accepted while a
// finished result still waits for the sink. The node count must be
// written through the configuration port only while the block is idle;
// the block does not enforce this. Values above 64 act as 64, and zero
// rejects every edge add. There is no clearing pass after reset: per-row
// valid bits stand in for the zeroed matrices; a clear operation drops them all.
module mixed_graph_reach_update (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration: node count.
    input  logic                             i_cfg_wr_en,
    input  logic [mgru_pkg::CFG_W-1:0]       i_cfg_wr_data,
    // Operation words in.
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // node_a [5:0], node_b [11:6], future_mask [75:12], drop_overlap [76],
    // zero fill [79:77].
    input  logic [mgru_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // operation [1:0].
    input  logic [1:0]                       s_axis_tuser,
    // Result words out.
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // status [0], cycle_found [1], zero fill [7:2].
    output logic [mgru_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import mgru_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // The controller owns sequencing; every matrix access and every
    // stored data value lives in the datapath.
    mgru_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    mgru_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_data     (s_axis_tdata),
        .i_in_user     (s_axis_tuser),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_out_data    (m_axis_tdata),
        .i_cmd         (cmd),
        .o_sts         (sts)
    );

endmodule

FILE: tb/mgru_reach_checker.sv
// ----------------------------------------------------------------------------
// mgru_reach_checker: result checker for the mixed graph reach update block
// Watches the configuration port and both stream channels, keeps its own
// copy of the reach and almost-reach matrices, and compares every result
// word with the flags predicted for the oldest outstanding operation word.
// ----------------------------------------------------------------------------
module mgru_reach_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [mgru_pkg::CFG_W-1:0]       i_cfg_wr_data,
    input  logic                             i_s_tvalid,
    input  logic                             i_s_tready,
    input  logic [mgru_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic [1:0]                       i_s_tuser,
    input  logic                             i_m_tvalid,
    input  logic                             i_m_tready,
    input  logic [mgru_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    output int                               o_mismatches,
    output int                               o_pending,
    output int                               o_results,
    output int                               o_rejects,
    output int                               o_cycles
);
    timeunit 1ns;
    timeprecision 1ps;

    import mgru_pkg::*;

    typedef struct packed {
        logic status;
        logic cycle_found;
    } t_flags;

    logic [63:0]        reach_q [MAX_NODES];
    logic [63:0]        almost_q [MAX_NODES];
    logic [CFG_W-1:0]   node_count_q;
    t_flags             flags_due [$];
    int                 mismatches;
    int                 results;
    int                 rejects;
    int                 cycles;

    function automatic logic [63:0] node_bit(int unsigned i);
        return 64'd1 << (i & 63);
    endfunction

    function automatic int unsigned nodes_active();
        return (node_count_q > MAX_NODES) ? MAX_NODES : int'(node_count_q);
    endfunction

    // Rows are rewritten in place in ascending order, so a later row picks
    // up whatever an earlier row already gained.
    function automatic void link_directed(int unsigned x, int unsigned y, int unsigned n);
        reach_q[x]  |= node_bit(y);
        reach_q[x]  |= reach_q[y];
        almost_q[x] |= almost_q[y];
        for (int unsigned z = 0; z < n; z++) begin
            if ((reach_q[z] & node_bit(x)) != 0) begin
                reach_q[z]  |= node_bit(y);
                reach_q[z]  |= reach_q[y];
                almost_q[z] |= almost_q[y];
            end
            if ((almost_q[z] & node_bit(x)) != 0) begin
                almost_q[z] |= node_bit(y);
                almost_q[z] |= reach_q[y];
            end
        end
    endfunction

    function automatic void link_bidirected(int unsigned x, int unsigned y, int unsigned n);
        almost_q[x] |= node_bit(y);
        almost_q[x] |= reach_q[y];
        almost_q[y] |= node_bit(x);
        almost_q[y] |= reach_q[x];
        for (int unsigned z = 0; z < n; z++) begin
            if ((reach_q[z] & node_bit(x)) != 0) begin
                almost_q[z] |= node_bit(y);
                almost_q[z] |= reach_q[y];
            end
            if ((reach_q[z] & node_bit(y)) != 0) begin
                almost_q[z] |= node_bit(x);
                almost_q[z] |= reach_q[x];
            end
        end
    endfunction

    function automatic void clear_matrices();
        for (int r = 0; r < MAX_NODES; r++) begin
            reach_q[r]  = '0;
            almost_q[r] = '0;
        end
    endfunction

    // Applies one operation word and returns the flags it must report.
    function automatic t_flags update_reach_matrices(t_op op, int unsigned a, int unsigned b,
                                                     logic [63:0] future, logic drop);
        int unsigned n;
        t_flags      f;
        n             = nodes_active();
        f.status      = 1'b0;
        f.cycle_found = 1'b0;
        case (op)
            OP_ADD_DIR: begin
                if (a >= n || b >= n || a == b)
                    f.status = 1'b1;
                else
                    link_directed(a, b, n);
            end
            OP_ADD_BI: begin
                if (a >= n || b >= n)
                    f.status = 1'b1;
                else
                    link_bidirected(a, b, n);
            end
            OP_PRUNE: begin
                for (int unsigned r = 0; r < n; r++) begin
                    if ((future & node_bit(r)) == 0) begin
                        reach_q[r]  = '0;
                        almost_q[r] = '0;
                    end
                    if (drop)
                        almost_q[r] &= ~reach_q[r];
                end
            end
            default: clear_matrices();
        endcase
        for (int unsigned r = 0; r < n; r++)
            if (((reach_q[r] | almost_q[r]) & node_bit(r)) != 0)
                f.cycle_found = 1'b1;
        return f;
    endfunction

    always @(posedge i_clk) begin
        t_flags exp_flags;
        t_flags new_flags;
        if (!i_rst_n) begin
            clear_matrices();
            node_count_q = NODE_COUNT_RESET;
            flags_due.delete();
            mismatches   = 0;
            results      = 0;
            rejects      = 0;
            cycles       = 0;
        end else begin
            if (i_cfg_wr_en)
                node_count_q = i_cfg_wr_data;
            if (i_s_tvalid && i_s_tready) begin
                new_flags = update_reach_matrices(t_op'(i_s_tuser),
                                                  i_s_tdata[5:0],
                                                  i_s_tdata[11:6],
                                                  i_s_tdata[75:12],
                                                  i_s_tdata[76]);
                flags_due.insert(flags_due.size(), new_flags);
            end
            if (i_m_tvalid && i_m_tready) begin
                results++;
                if (flags_due.size() == 0) begin
                    $display("%0t: result word %b with no operation outstanding",
                             $time, i_m_tdata);
                    mismatches++;
                end else begin
                    exp_flags = flags_due.pop_front();
                    rejects  += exp_flags.status;
                    cycles   += exp_flags.cycle_found;
                    if (i_m_tdata[0] !== exp_flags.status) begin
                        $display("%0t: status expected %b, got %b",
                                 $time, exp_flags.status, i_m_tdata[0]);
                        mismatches++;
                    end
                    if (i_m_tdata[1] !== exp_flags.cycle_found) begin
                        $display("%0t: cycle_found expected %b, got %b",
                                 $time, exp_flags.cycle_found, i_m_tdata[1]);
                        mismatches++;
                    end
                end
            end
        end
        o_mismatches <= mismatches;
        o_pending    <= flags_due.size();
        o_results    <= results;
        o_rejects    <= rejects;
        o_cycles     <= cycles;
    end

endmodule

FILE: tb/mixed_graph_reach_update_tb.sv
// ----------------------------------------------------------------------------
// mixed_graph_reach_update_tb: top-level testbench for the reach update block
// Drives operation words under several node counts with random gaps and
// result backpressure; a separate checker predicts and compares the flags.
// ----------------------------------------------------------------------------
module mixed_graph_reach_update_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mgru_pkg::*;

    // A no-accept stretch covers the longest sender gap, a full 64-row
    // edge add and the longest receiver stall, so
    // this bound is many times over what a healthy block needs.
    localparam int IDLE_LIMIT = 3000;
    localparam int N_PHASES   = 10;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic [CFG_W-1:0]       i_cfg_wr_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic [1:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    int mismatches;
    int pending;
    int results;
    int rejects;
    int cycles;

    // The sender tracks the node count it last wrote so that random node
    // indexes mostly land inside the range in use.
    logic [CFG_W-1:0] cur_node_count;
    int               words_sent;
    int               settings_used;
    bit               no_gaps;
    int               idle_cycles;

    // Node counts of the random phases and how many words each one gets.
    // The list includes zero, one, the largest count, and values above it.
    int phase_count [N_PHASES] = '{64, 12, 1, 0, 2, 100, 5, 127, 33, 64};
    int phase_words [N_PHASES] = '{200, 120, 30, 20, 40, 150, 80, 150, 100, 60};

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    mixed_graph_reach_update dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    mgru_reach_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tuser     (s_axis_tuser),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .o_mismatches  (mismatches),
        .o_pending     (pending),
        .o_results     (results),
        .o_rejects     (rejects),
        .o_cycles      (cycles)
    );

    // Gap lengths: mostly none or short, now and then a long one, and none
    // at all while a burst stretch is running.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    // Sends one operation word and returns at the edge where it was taken.
    // tvalid stays high across back-to-back words, so this task only lowers
    // it when a gap is inserted; drain also lowers it.
    task automatic send_word(t_op op, logic [5:0] a, logic [5:0] b,
                             logic [63:0] future, logic drop);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {3'b000, drop, future, b, a};
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        words_sent++;
    endtask

    // Holds the sender off until every word sent so far has its result.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending != 0);
    endtask

    // The node count is only written while the block is idle.
    task automatic write_node_count(logic [CFG_W-1:0] value);
        drain();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        cur_node_count = value;
        settings_used++;
    endtask

    // One random word. Most words are edge adds between nodes in use so
    // the matrices fill up; a few use raw indexes to hit the reject path,
    // and prunes mostly spare all but a row or two so the graph survives.
    task automatic send_random_word();
        int unsigned n;
        int          r;
        int          style;
        t_op         op;
        logic [5:0]  a;
        logic [5:0]  b;
        logic [63:0] future;
        n = (cur_node_count > MAX_NODES) ? MAX_NODES : cur_node_count;
        r = $urandom_range(0, 99);
        if (r < 45)
            op = OP_ADD_DIR;
        else if (r < 75)
            op = OP_ADD_BI;
        else if (r < 96)
            op = OP_PRUNE;
        else
            op = OP_CLEAR;
        if (n == 0 || $urandom_range(0, 9) == 0) begin
            a = 6'($urandom);
            b = 6'($urandom);
        end else begin
            a = 6'($urandom_range(0, n - 1));
            b = 6'($urandom_range(0, n - 1));
        end
        if ($urandom_range(0, 29) == 0)
            b = a;
        style = $urandom_range(0, 9);
        if (op != OP_PRUNE || style < 2)
            future = {$urandom, $urandom};
        else if (style < 8)
            future = ~((64'd1 << $urandom_range(0, 63)) | (64'd1 << $urandom_range(0, 63)));
        else if (style < 9)
            future = '1;
        else
            future = '0;
        send_word(op, a, b, future, 1'($urandom_range(0, 1)));
    endtask

    // Result backpressure: ready runs high for a while, then may drop for
    // a short or, rarely, a long stall. A high stretch always waits on the
    // clock before ready can drop, so ready never gets two assignments in one step.
    initial begin
        int hi;
        int lo;
        int r;
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        forever begin
            r  = $urandom_range(0, 99);
            hi = (r < 15) ? $urandom_range(20, 80) : $urandom_range(1, 6);
            r  = $urandom_range(0, 99);
            if (r < 50)
                lo = 0;
            else if (r < 92)
                lo = $urandom_range(1, 4);
            else
                lo = $urandom_range(10, 40);
            m_axis_tready <= 1'b1;
            repeat (hi) @(posedge i_clk);
            if (lo > 0) begin
                m_axis_tready <= 1'b0;
                repeat (lo) @(posedge i_clk);
            end
        end
    end

    // Watchdog: a long run of cycles with nothing accepted means a hang.
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_wr_en    = 1'b0;
        i_cfg_wr_data  = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = OP_CLEAR;
        cur_node_count = NODE_COUNT_RESET;
        words_sent     = 0;
        settings_used  = 1;
        no_gaps        = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed words at the reset node count of 64: extreme nodes, a
        // directed cycle, a rejected directed self edge, an accepted
        // bidirected self edge, and prunes with full, partial and empty
        // masks, with and without dropping the overlap.
        send_word(OP_CLEAR,   6'd0,  6'd0,  '0, 1'b0);
        send_word(OP_ADD_DIR, 6'd0,  6'd63, '0, 1'b0);
        send_word(OP_ADD_DIR, 6'd63, 6'd0,  '1, 1'b1);
        send_word(OP_ADD_DIR, 6'd5,  6'd5,  '0, 1'b0);
        send_word(OP_PRUNE,   6'd0,  6'd0,  '1, 1'b1);
        send_word(OP_ADD_BI,  6'd7,  6'd7,  '0, 1'b0);
        send_word(OP_PRUNE,   6'd63, 6'd63, ~(64'd1 << 7), 1'b0);
        send_word(OP_CLEAR,   6'd63, 6'd63, '1, 1'b1);
        send_word(OP_ADD_BI,  6'd1,  6'd2,  '0, 1'b0);
        send_word(OP_ADD_DIR, 6'd3,  6'd1,  '0, 1'b0);
        send_word(OP_ADD_DIR, 6'd2,  6'd4,  '0, 1'b0);
        send_word(OP_PRUNE,   6'd0,  6'd0,  '1, 1'b1);
        send_word(OP_ADD_DIR, 6'd4,  6'd3,  '0, 1'b0);
        send_word(OP_PRUNE,   6'd0,  6'd0,  '0, 1'b0);
        send_word(OP_ADD_DIR, 6'd62, 6'd63, '0, 1'b0);
        send_word(OP_ADD_BI,  6'd63, 6'd62, '0, 1'b0);
        send_word(OP_PRUNE,   6'd0,  6'd0,  '1, 1'b1);

        // A small node count: indexes at or above it are rejected, and
        // mask bits above it must not matter.
        write_node_count(7'd8);
        send_word(OP_ADD_DIR, 6'd8,  6'd1,  '0, 1'b0);
        send_word(OP_ADD_DIR, 6'd1,  6'd63, '0, 1'b0);
        send_word(OP_ADD_BI,  6'd0,  6'd8,  '0, 1'b0);
        send_word(OP_PRUNE,   6'd0,  6'd0,  64'hFFFF_FFFF_FFFF_FF00, 1'b1);

        // No node in use: every edge add is rejected and nothing cycles.
        write_node_count(7'd0);
        send_word(OP_ADD_DIR, 6'd0,  6'd1,  '0, 1'b0);
        send_word(OP_ADD_BI,  6'd0,  6'd0,  '0, 1'b0);
        send_word(OP_PRUNE,   6'd0,  6'd0,  '0, 1'b1);
        send_word(OP_CLEAR,   6'd0,  6'd0,  '0, 1'b0);

        // Random phases. The matrices are not cleared between settings,
        // so rows left behind by a larger node count reappear later.
        // Every fourth stretch of 64 words runs without sender gaps.
        for (int p = 0; p < N_PHASES; p++) begin
            write_node_count(CFG_W'(phase_count[p]));
            for (int i = 0; i < phase_words[p]; i++) begin
                no_gaps = ((i / 64) % 4) == 3;
                send_random_word();
            end
        end

        drain();
        repeat (20) @(posedge i_clk);

        $display("Sent %0d operation words across %0d node-count settings.",
                 words_sent, settings_used);
        $display("Checked %0d results: %0d rejected, %0d reporting a cycle.",
                 results, rejects, cycles);
        if (mismatches == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

FILE: filelist.f
sv/mgru_pkg.sv
sv/mgru_ram.sv
sv/mgru_dp.sv
sv/mgru_ctrl.sv
sv/mixed_graph_reach_update.sv
tb/mgru_reach_checker.sv
tb/mixed_graph_reach_update_tb.sv
